// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, held off while reset is high.
`define ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ----- hdl/klt_pkg.sv -----
// Shared types and constants of the keyed lock table.
package klt_pkg;

   localparam int CAPACITY = 32;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   localparam int TRACK_W = 3;
   localparam int STEP_W  = 5;
   localparam int PARAM_W = 8;
   localparam int PROB_W  = 8;
   localparam int OP_W    = 3;

   localparam logic [OP_W-1:0] OP_SET         = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR       = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_STEP  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_TRACK = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL   = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND        = 3'd5;

   typedef struct packed {
      logic               valid;
      logic [TRACK_W-1:0] track;
      logic [STEP_W-1:0]  step;
      logic [PARAM_W-1:0] param;
      logic [PROB_W-1:0]  prob;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_RESP
   } state_type;

endpackage

// ----- hdl/klt_cell.sv -----
// One table slot: holds an entry and passes it to its neighbor while the ring turns.
module klt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  klt_pkg::entry_type ent_in,
   output klt_pkg::entry_type ent_out
);

   logic                        valid_ff;
   logic [klt_pkg::TRACK_W-1:0] track_ff;
   logic [klt_pkg::STEP_W-1:0]  step_ff;
   logic [klt_pkg::PARAM_W-1:0] param_ff;
   logic [klt_pkg::PROB_W-1:0]  prob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= ent_in.valid;
      end
   end

   // Key and probability carry no reset; a free slot is never compared.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         track_ff <= ent_in.track;
         step_ff  <= ent_in.step;
         param_ff <= ent_in.param;
         prob_ff  <= ent_in.prob;
      end
   end

   always_comb begin
      ent_out.valid = valid_ff;
      ent_out.track = track_ff;
      ent_out.step  = step_ff;
      ent_out.param = param_ff;
      ent_out.prob  = prob_ff;
   end

endmodule

// ----- hdl/klt_ctrl.sv -----
// Sequencer and compare head of the table: walks the ring, edits entries, builds the result.
module klt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [klt_pkg::OP_W-1:0]    req_type,
   input  logic [klt_pkg::TRACK_W-1:0] req_track,
   input  logic [klt_pkg::STEP_W-1:0]  req_step,
   input  logic [klt_pkg::PARAM_W-1:0] req_param,
   input  logic [klt_pkg::PROB_W-1:0]  req_prob,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_ok,
   output logic [klt_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [klt_pkg::COUNT_W-1:0] rsp_live_count,
   output logic                        shift_en,
   input  klt_pkg::entry_type          head_in,
   output klt_pkg::entry_type          head_out
);

   klt_pkg::state_type state_ff, state_in;

   logic [klt_pkg::SLOT_W-1:0]  idx_ff;
   logic [klt_pkg::OP_W-1:0]    op_ff;
   logic [klt_pkg::TRACK_W-1:0] track_ff;
   logic [klt_pkg::STEP_W-1:0]  step_ff;
   logic [klt_pkg::PARAM_W-1:0] param_ff;
   logic [klt_pkg::PROB_W-1:0]  prob_ff;
   logic                        hit_found_ff;
   logic [klt_pkg::SLOT_W-1:0]  hit_idx_ff;
   logic                        free_found_ff;
   logic [klt_pkg::SLOT_W-1:0]  free_idx_ff;
   logic [klt_pkg::COUNT_W-1:0] occ_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_ok_ff;
   logic [klt_pkg::SLOT_W-1:0]  rsp_slot_ff;
   logic [klt_pkg::COUNT_W-1:0] rsp_count_ff;

   logic                        accept;
   logic                        last;
   logic                        load_rsp;
   logic                        match_key;
   logic                        match_ts;
   logic                        match_t;
   logic                        dec;
   logic                        inc;
   logic                        res_ok;
   logic [klt_pkg::SLOT_W-1:0]  res_slot;
   logic [klt_pkg::SLOT_W-1:0]  target;

   assign accept = req_valid && !req_stall;
   assign last   = (idx_ff == klt_pkg::SLOT_W'(klt_pkg::CAPACITY - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         klt_pkg::ST_IDLE: begin
            if (req_valid) state_in = klt_pkg::ST_SCAN;
         end
         klt_pkg::ST_SCAN: begin
            if (last) begin
               state_in = (op_ff == klt_pkg::OP_SET) ? klt_pkg::ST_APPLY : klt_pkg::ST_RESP;
            end
         end
         klt_pkg::ST_APPLY: begin
            if (last) state_in = klt_pkg::ST_RESP;
         end
         klt_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = klt_pkg::ST_IDLE;
         end
         default: state_in = klt_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      shift_en  = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         klt_pkg::ST_IDLE:  req_stall = 1'b0;
         klt_pkg::ST_SCAN:  shift_en  = 1'b1;
         klt_pkg::ST_APPLY: shift_en  = 1'b1;
         klt_pkg::ST_RESP:  load_rsp  = !rsp_valid_ff || !rsp_stall;
         default:           req_stall = 1'b1;
      endcase
   end

   always_comb begin
      match_t   = head_in.valid && (head_in.track == track_ff);
      match_ts  = match_t && (head_in.step == step_ff);
      match_key = match_ts && (head_in.param == param_ff);
      target    = hit_found_ff ? hit_idx_ff : free_idx_ff;
   end

   // Edit the entry at the head as it moves back to the tail of the ring.
   always_comb begin
      head_out = head_in;
      dec      = 1'b0;
      inc      = 1'b0;
      if (state_ff == klt_pkg::ST_SCAN) begin
         case (op_ff)
            klt_pkg::OP_CLEAR: begin
               if (match_key && !hit_found_ff) begin
                  head_out.valid = 1'b0;
                  dec            = 1'b1;
               end
            end
            klt_pkg::OP_CLEAR_STEP: begin
               if (match_ts) begin
                  head_out.valid = 1'b0;
                  dec            = 1'b1;
               end
            end
            klt_pkg::OP_CLEAR_TRACK: begin
               if (match_t) begin
                  head_out.valid = 1'b0;
                  dec            = 1'b1;
               end
            end
            klt_pkg::OP_CLEAR_ALL: begin
               if (head_in.valid) begin
                  head_out.valid = 1'b0;
                  dec            = 1'b1;
               end
            end
            default: begin
               dec = 1'b0;
            end
         endcase
      end else if (state_ff == klt_pkg::ST_APPLY) begin
         if (idx_ff == target) begin
            if (hit_found_ff) begin
               head_out.prob = prob_ff;
            end else if (free_found_ff) begin
               head_out.valid = 1'b1;
               head_out.track = track_ff;
               head_out.step  = step_ff;
               head_out.param = param_ff;
               head_out.prob  = prob_ff;
               inc            = 1'b1;
            end
         end
      end
   end

   // result of the finished pass
   always_comb begin
      res_ok   = 1'b0;
      res_slot = '0;
      case (op_ff)
         klt_pkg::OP_SET: begin
            res_ok   = hit_found_ff || free_found_ff;
            res_slot = hit_found_ff ? hit_idx_ff : (free_found_ff ? free_idx_ff : '0);
         end
         klt_pkg::OP_CLEAR, klt_pkg::OP_FIND: begin
            res_ok   = hit_found_ff;
            res_slot = hit_found_ff ? hit_idx_ff : '0;
         end
         default: begin
            res_ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= klt_pkg::ST_IDLE;
         idx_ff        <= '0;
         occ_ff        <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (shift_en) begin
            idx_ff <= last ? '0 : idx_ff + 1'b1;
         end
         if (dec) begin
            occ_ff <= occ_ff - 1'b1;
         end else if (inc) begin
            occ_ff <= occ_ff + 1'b1;
         end
         if (accept) begin
            hit_found_ff  <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (state_ff == klt_pkg::ST_SCAN) begin
            if (match_key && !hit_found_ff) hit_found_ff <= 1'b1;
            if (!head_in.valid && !free_found_ff) free_found_ff <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_type;
         track_ff <= req_track;
         step_ff  <= req_step;
         param_ff <= req_param;
         prob_ff  <= req_prob;
      end
      if (state_ff == klt_pkg::ST_SCAN) begin
         if (match_key && !hit_found_ff) hit_idx_ff <= idx_ff;
         if (!head_in.valid && !free_found_ff) free_idx_ff <= idx_ff;
      end
      if (load_rsp) begin
         rsp_ok_ff    <= res_ok;
         rsp_slot_ff  <= res_slot;
         rsp_count_ff <= occ_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_live_count = rsp_count_ff;

endmodule

// ----- hdl/keyed_lock_table_top.sv -----
// Top level of the keyed lock table: ring of slot cells plus sequencer.
// The table holds 32 entries keyed by (track, step, param), each with an 8-bit
// probability, in a ring of identical slot cells. A transaction is accepted only
// while the block is idle; the ring then turns once so that every slot passes the
// single compare head in index order, which finds the lowest matching and the
// lowest free slot and frees entries on the fly for clear, clear_step,
// clear_track and clear_all. find and all clears return their result after one
// turn of the ring; set needs a second turn of the ring to write the chosen
// slot. During a turn one slot per cycle passes the compare head. The result
// sits in an output register, so a stalled result does not hold back the next
// transaction's walk until it is ready to be delivered. Request codes 6 and 7
// walk the ring without change and return ok low, slot zero and the current
// live count. Reset empties the table at once through the per-slot valid bits.
module keyed_lock_table_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [klt_pkg::OP_W-1:0]    req_type,
   input  logic [klt_pkg::TRACK_W-1:0] req_track,
   input  logic [klt_pkg::STEP_W-1:0]  req_step,
   input  logic [klt_pkg::PARAM_W-1:0] req_param,
   input  logic [klt_pkg::PROB_W-1:0]  req_prob,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_ok,
   output logic [klt_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [klt_pkg::COUNT_W-1:0] rsp_live_count
);

   // Cell k holds the slot at head distance k; cell 0 is the compare head.
   klt_pkg::entry_type cell_q [klt_pkg::CAPACITY];
   klt_pkg::entry_type head_out;
   logic               shift_en;

   genvar k;
   generate
      for (k = 0; k < klt_pkg::CAPACITY; k++) begin : g_cell
         if (k == klt_pkg::CAPACITY - 1) begin : g_tail
            // Close the ring: the edited head entry re-enters at the tail.
            klt_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (shift_en),
               .ent_in   (head_out),
               .ent_out  (cell_q[k])
            );
         end else begin : g_body
            // Advance each entry one cell toward the head.
            klt_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (shift_en),
               .ent_in   (cell_q[k+1]),
               .ent_out  (cell_q[k])
            );
         end
      end
   endgenerate

   // Sequence the walk, edit at the head, hold the result until taken.
   klt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_track      (req_track),
      .req_step       (req_step),
      .req_param      (req_param),
      .req_prob       (req_prob),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_slot       (rsp_slot),
      .rsp_live_count (rsp_live_count),
      .shift_en       (shift_en),
      .head_in        (cell_q[0]),
      .head_out       (head_out)
   );

endmodule

// ----- hdl/klt_checker.sv -----
// Port-level assertions for the keyed lock table, bound to the top level.
`include "assert_macros.svh"

module klt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_ok,
   input logic [klt_pkg::SLOT_W-1:0]  rsp_slot,
   input logic [klt_pkg::COUNT_W-1:0] rsp_live_count
);

   `ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, rsp_live_count <= klt_pkg::CAPACITY)

   `ASSERT_IMPL(a_miss_slot_zero, clock, reset, rsp_valid && !rsp_ok, rsp_slot == '0)

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_ok) && $stable(rsp_slot) && $stable(rsp_live_count))

endmodule

bind keyed_lock_table_top klt_checker u_klt_checker (.*);

// ----- test/keyed_lock_table_checker.sv -----
// Result predictor and comparator for the keyed lock table.
module keyed_lock_table_checker
   import klt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [OP_W-1:0]    req_type,
   input  logic [TRACK_W-1:0] req_track,
   input  logic [STEP_W-1:0]  req_step,
   input  logic [PARAM_W-1:0] req_param,
   input  logic [PROB_W-1:0]  req_prob,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_ok,
   input  logic [SLOT_W-1:0]  rsp_slot,
   input  logic [COUNT_W-1:0] rsp_live_count,
   output int unsigned        fail_count,
   output int unsigned        pending
);

   typedef struct packed {
      logic               ok;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] live_count;
   } lock_rsp_type;

   entry_type          lock_entries [CAPACITY];
   logic [COUNT_W-1:0] live_entries;
   lock_rsp_type       lock_rsp_q [$];
   lock_rsp_type       oldest_rsp;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   // Apply one request to the shadow table and queue the result it yields.
   task automatic update_lock_table(input logic [OP_W-1:0] op,
                                    input logic [TRACK_W-1:0] trk,
                                    input logic [STEP_W-1:0] stp,
                                    input logic [PARAM_W-1:0] prm,
                                    input logic [PROB_W-1:0] prb);
      int           hit_slot;
      int           free_slot;
      lock_rsp_type rsp;
      hit_slot  = -1;
      free_slot = -1;
      // walk downward so the lowest matching and lowest free slot win
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (lock_entries[i].valid && lock_entries[i].track == trk &&
             lock_entries[i].step == stp && lock_entries[i].param == prm) begin
            hit_slot = i;
         end
         if (!lock_entries[i].valid) begin
            free_slot = i;
         end
      end
      rsp = '0;
      case (op)
         OP_SET: begin
            if (hit_slot >= 0) begin
               lock_entries[hit_slot].prob = prb;
               rsp.ok   = 1'b1;
               rsp.slot = hit_slot[SLOT_W-1:0];
            end else if (free_slot >= 0) begin
               lock_entries[free_slot].valid = 1'b1;
               lock_entries[free_slot].track = trk;
               lock_entries[free_slot].step  = stp;
               lock_entries[free_slot].param = prm;
               lock_entries[free_slot].prob  = prb;
               live_entries++;
               rsp.ok   = 1'b1;
               rsp.slot = free_slot[SLOT_W-1:0];
            end
         end
         OP_CLEAR: begin
            if (hit_slot >= 0) begin
               lock_entries[hit_slot].valid = 1'b0;
               live_entries--;
               rsp.ok   = 1'b1;
               rsp.slot = hit_slot[SLOT_W-1:0];
            end
         end
         OP_CLEAR_STEP: begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (lock_entries[i].valid && lock_entries[i].track == trk &&
                   lock_entries[i].step == stp) begin
                  lock_entries[i].valid = 1'b0;
                  live_entries--;
               end
            end
         end
         OP_CLEAR_TRACK: begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (lock_entries[i].valid && lock_entries[i].track == trk) begin
                  lock_entries[i].valid = 1'b0;
                  live_entries--;
               end
            end
         end
         OP_CLEAR_ALL: begin
            for (int i = 0; i < CAPACITY; i++) begin
               lock_entries[i].valid = 1'b0;
            end
            live_entries = '0;
         end
         OP_FIND: begin
            if (hit_slot >= 0) begin
               rsp.ok   = 1'b1;
               rsp.slot = hit_slot[SLOT_W-1:0];
            end
         end
         default: begin
         end
      endcase
      rsp.live_count = live_entries;
      lock_rsp_q.push_back(rsp);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) begin
            lock_entries[i].valid = 1'b0;
         end
         live_entries = '0;
         lock_rsp_q.delete();
      end else begin
         // retire the result before queuing a new request
         if (rsp_valid && !rsp_stall) begin
            if (lock_rsp_q.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               oldest_rsp = lock_rsp_q.pop_front();
               if (rsp_ok !== oldest_rsp.ok) begin
                  report_mismatch($sformatf("ok: got %0d, expected %0d",
                                            rsp_ok, oldest_rsp.ok));
               end
               if (rsp_slot !== oldest_rsp.slot) begin
                  report_mismatch($sformatf("slot: got %0d, expected %0d",
                                            rsp_slot, oldest_rsp.slot));
               end
               if (rsp_live_count !== oldest_rsp.live_count) begin
                  report_mismatch($sformatf("live_count: got %0d, expected %0d",
                                            rsp_live_count, oldest_rsp.live_count));
               end
            end
         end
         if (req_valid && !req_stall) begin
            update_lock_table(req_type, req_track, req_step, req_param, req_prob);
         end
      end
      pending = lock_rsp_q.size();
   end

endmodule

// ----- test/tb_keyed_lock_table_top.sv -----
// Stimulus, clocking and verdict for the keyed lock table.
module tb_keyed_lock_table_top;
   import klt_pkg::*;

   // Request codes the block ignores; they still return one result.
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   localparam int RANDOM_ITEMS = 400;
   // A set walks the ring twice; leave margin on top.
   localparam int DRAIN_CYCLES = 100;
   // Slowest run is a few hundred items, each at worst a set with its two ring turns.
   localparam int CYCLE_LIMIT  = 400000;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic [OP_W-1:0]    req_type  = OP_FIND;
   logic [TRACK_W-1:0] req_track = '0;
   logic [STEP_W-1:0]  req_step  = '0;
   logic [PARAM_W-1:0] req_param = '0;
   logic [PROB_W-1:0]  req_prob  = '0;
   logic               rsp_stall = 1'b1;
   logic               req_stall;
   logic               rsp_valid;
   logic               rsp_ok;
   logic [SLOT_W-1:0]  rsp_slot;
   logic [COUNT_W-1:0] rsp_live_count;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned cycle_count;
   int          send_idle_pct = 22;
   int          recv_idle_pct = 65;
   int          items_sent    = 0;

   // Key neighborhood of the current random sequence; small so keys collide.
   logic [TRACK_W-1:0] pool_track;
   logic [STEP_W-1:0]  pool_step;
   logic [PARAM_W-1:0] pool_param;

   keyed_lock_table_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_track      (req_track),
      .req_step       (req_step),
      .req_param      (req_param),
      .req_prob       (req_prob),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_slot       (rsp_slot),
      .rsp_live_count (rsp_live_count)
   );

   keyed_lock_table_checker i_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_track      (req_track),
      .req_step       (req_step),
      .req_param      (req_param),
      .req_prob       (req_prob),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_slot       (rsp_slot),
      .rsp_live_count (rsp_live_count),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the result channel at random; inputs move on the falling edge only.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Count cycles and abort if the run hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL keyed_lock_table_top");
      $finish;
   end

   // Present one transaction and hold it until the block takes it.
   // Enter and leave on a falling edge; valid is set at most once per edge.
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic [TRACK_W-1:0] trk,
                               input logic [STEP_W-1:0] stp,
                               input logic [PARAM_W-1:0] prm,
                               input logic [PROB_W-1:0] prb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= op;
      req_track <= trk;
      req_step  <= stp;
      req_param <= prm;
      req_prob  <= prb;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
      // ignored codes do not count toward the random budget
      if (op <= OP_FIND) begin
         items_sent++;
      end
   endtask

   // Send a request whose key lies near the current pool, so hits are common.
   task automatic send_pooled(input logic [OP_W-1:0] op);
      send_request(op, pool_track ^ TRACK_W'($urandom_range(1)),
                   pool_step ^ STEP_W'($urandom_range(1)),
                   pool_param ^ PARAM_W'($urandom_range(3)),
                   PROB_W'($urandom));
   endtask

   // Drop valid and hold off until every outstanding result has returned.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   // Fill the table past capacity; probe a known key, then the full condition.
   task automatic fill_burst();
      logic [TRACK_W-1:0] first_track;
      logic [STEP_W-1:0]  first_step;
      logic [PARAM_W-1:0] first_param;
      int                 fill_count;
      first_track = TRACK_W'($urandom);
      first_step  = STEP_W'($urandom);
      first_param = PARAM_W'($urandom);
      fill_count  = $urandom_range(CAPACITY + 3, CAPACITY);
      send_request(OP_CLEAR_ALL, TRACK_W'($urandom), STEP_W'($urandom),
                   PARAM_W'($urandom), PROB_W'($urandom));
      send_request(OP_SET, first_track, first_step, first_param, PROB_W'($urandom));
      for (int i = 0; i < fill_count; i++) begin
         send_request(OP_SET, TRACK_W'($urandom), STEP_W'($urandom),
                      PARAM_W'($urandom), PROB_W'($urandom));
      end
      send_request(OP_FIND, first_track, first_step, first_param, PROB_W'($urandom));
      send_request(OP_SET, TRACK_W'($urandom), STEP_W'($urandom),
                   PARAM_W'($urandom), PROB_W'($urandom));
      send_request(OP_CLEAR, first_track, first_step, first_param, PROB_W'($urandom));
      send_request(OP_SET, TRACK_W'($urandom), STEP_W'($urandom),
                   PARAM_W'($urandom), PROB_W'($urandom));
      send_request(OP_SET, TRACK_W'($urandom), STEP_W'($urandom),
                   PARAM_W'($urandom), PROB_W'($urandom));
   endtask

   initial begin
      int seq_kind;
      int seq_len;
      int pick;
      int phase;
      int cur_phase;
      int random_start;

      // Hold reset from the start, then release it once.
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: empty-table misses, key extremes, overwrite, reuse of a
      // freed slot, every bulk clear, and the ignored codes.
      send_request(OP_FIND,        3'd0, 5'd0,  8'd0,   8'd0);
      send_request(OP_CLEAR,       3'd0, 5'd0,  8'd0,   8'd0);
      send_request(OP_SET,         3'd0, 5'd0,  8'd0,   8'd0);
      send_request(OP_SET,         3'd7, 5'd31, 8'd255, 8'd255);
      send_request(OP_SET,         3'd7, 5'd31, 8'd254, 8'd128);
      send_request(OP_SET,         3'd0, 5'd0,  8'd0,   8'd255);
      send_request(OP_FIND,        3'd7, 5'd31, 8'd255, 8'd0);
      send_request(OP_SET,         3'd7, 5'd0,  8'd1,   8'd1);
      send_request(OP_SET,         3'd3, 5'd31, 8'd0,   8'd127);
      send_request(OP_CLEAR,       3'd7, 5'd31, 8'd255, 8'd0);
      send_request(OP_SET,         3'd5, 5'd10, 8'd85,  8'd170);
      send_request(OP_CLEAR,       3'd7, 5'd31, 8'd255, 8'd0);
      send_request(OP_CLEAR_STEP,  3'd7, 5'd31, 8'd0,   8'd0);
      send_request(OP_FIND,        3'd7, 5'd31, 8'd254, 8'd0);
      send_request(OP_CLEAR_TRACK, 3'd7, 5'd0,  8'd0,   8'd0);
      send_request(OP_SPARE_LO,    3'd5, 5'd10, 8'd85,  8'd255);
      send_request(OP_SPARE_HI,    3'd2, 5'd21, 8'd170, 8'd85);
      send_request(OP_FIND,        3'd5, 5'd10, 8'd85,  8'd0);
      send_request(OP_CLEAR_ALL,   3'd0, 5'd0,  8'd0,   8'd0);
      send_request(OP_FIND,        3'd0, 5'd0,  8'd0,   8'd0);
      send_request(OP_SET,         3'd2, 5'd21, 8'd170, 8'd85);
      send_request(OP_CLEAR_TRACK, 3'd2, 5'd0,  8'd0,   8'd0);
      send_request(OP_CLEAR_ALL,   3'd7, 5'd31, 8'd255, 8'd255);

      // Pause the sender once until the table has answered everything.
      hold_until_drained();

      // Random part in three idle phases: sender light / receiver heavy, then
      // swapped, then no idling at all. Drain at each phase change.
      random_start = items_sent;
      cur_phase    = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         phase = ((items_sent - random_start) * 3) / RANDOM_ITEMS;
         if (phase != cur_phase) begin
            cur_phase = phase;
            hold_until_drained();
            send_idle_pct = (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 1) ? 22 : 0;
         end
         pool_track = TRACK_W'($urandom);
         pool_step  = STEP_W'($urandom);
         pool_param = PARAM_W'($urandom);
         seq_kind   = $urandom_range(99);
         if (seq_kind < 60) begin
            // edit session on a small key neighborhood
            seq_len = $urandom_range(20, 8);
            for (int i = 0; i < seq_len; i++) begin
               pick = $urandom_range(99);
               if (pick < 45) begin
                  send_pooled(OP_SET);
               end else if (pick < 60) begin
                  send_pooled(OP_CLEAR);
               end else if (pick < 78) begin
                  send_pooled(OP_FIND);
               end else if (pick < 86) begin
                  send_pooled(OP_CLEAR_STEP);
               end else if (pick < 92) begin
                  send_pooled(OP_CLEAR_TRACK);
               end else if (pick < 95) begin
                  send_pooled(OP_CLEAR_ALL);
               end else begin
                  send_pooled(($urandom_range(1) == 0) ? OP_SPARE_LO : OP_SPARE_HI);
               end
            end
         end else if (seq_kind < 80) begin
            fill_burst();
         end else begin
            // noise: any code, any key
            seq_len = $urandom_range(6, 3);
            for (int i = 0; i < seq_len; i++) begin
               send_request(OP_W'($urandom), TRACK_W'($urandom), STEP_W'($urandom),
                            PARAM_W'($urandom), PROB_W'($urandom));
            end
         end
      end

      // Wait out the outstanding results, then give stray results time to show.
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0) begin
         $display("PASS keyed_lock_table_top");
      end else begin
         $display("FAIL keyed_lock_table_top");
      end
      $finish;
   end

endmodule

// ----- keyed_lock_table_top.f -----
+incdir+hdl
hdl/klt_pkg.sv
hdl/klt_cell.sv
hdl/klt_ctrl.sv
hdl/keyed_lock_table_top.sv
hdl/klt_checker.sv
test/keyed_lock_table_checker.sv
test/tb_keyed_lock_table_top.sv
